### design/queue_health_watchdog_top_assert.svh
// Assertion macros used by the queue health watchdog datapath.
`ifndef QUEUE_HEALTH_WATCHDOG_TOP_ASSERT_SVH
`define QUEUE_HEALTH_WATCHDOG_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define QHW_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define QHW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/qhw_pkg.sv
// Package: types, constants and helper functions of the queue health watchdog.
`timescale 1ns / 1ps
`default_nettype none

package qhw_pkg;

   localparam int GROUPS_DEFAULT           = 64;
   localparam int HISTORY_DEPTH_DEFAULT    = 16;
   localparam int TICKS_PER_SECOND_DEFAULT = 1000;
   localparam int AGE_TENS                 = 10;

   localparam int           CSR_ADDR_WIDTH   = 4;
   localparam int           CSR_DATA_WIDTH   = 64;
   localparam logic         CSR_IDX_THRESHOLD = 1'b0;
   localparam logic         CSR_IDX_GROUPS    = 1'b1;
   localparam logic [7:0]   THRESHOLD_RESET   = 8'd3;

   localparam logic KIND_CHECK  = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [31:0] now_time;
      logic [31:0] catas_word;
      logic [5:0]  group_index;
   } req_type;

   typedef struct packed {
      logic        alert;
      logic        fatal;
      logic [4:0]  failure_count;
      logic        catas_failed;
      logic [31:0] catas_value;
      logic        group_failed;
      logic [5:0]  failed_group;
      logic [63:0] session_mask;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_AGE_READ,
      ST_AGE_CHECK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic record;
      logic start;
      logic drop;
      logic commit;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic fatal;
      logic cat_pend;
      logic grp_pend;
      logic expired;
      logic out_busy;
   } stat_type;

   function automatic logic [31:0] swap_bytes(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   function automatic logic [63:0] group_mask(input int groups);
      logic [63:0] m;
      for (int i = 0; i < 64; i++) begin
         m[i] = (i < groups);
      end
      return m;
   endfunction

   // Lowest set bit: per-byte search, then lowest nonzero byte.
   function automatic logic [5:0] lowest_set(input logic [63:0] v);
      logic [7:0] nz;
      logic [2:0] bit_idx [8];
      logic [2:0] byte_idx;
      for (int b = 0; b < 8; b++) begin
         nz[b]      = |v[8*b +: 8];
         bit_idx[b] = 3'd0;
         for (int k = 7; k >= 0; k--) begin
            if (v[8*b + k]) begin
               bit_idx[b] = 3'(k);
            end
         end
      end
      byte_idx = 3'd0;
      for (int b = 7; b >= 0; b--) begin
         if (nz[b]) begin
            byte_idx = 3'(b);
         end
      end
      return {byte_idx, bit_idx[byte_idx]};
   endfunction

endpackage

`default_nettype wire

### design/queue_health_watchdog_top.sv
// Top level of the queue health watchdog: ports, CSR block, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Queue health watchdog. Each request is either a group ok report (kind 1),
// which marks one receive trap group as seen, or a check cycle (kind 0).
// A check cycle logs a nonzero byte-swapped catastrophic word as a fatal
// failure, then (except on the very first check) logs the lowest group whose
// observed state differs from the expected set, then reloads the expected
// set from monitored_groups, clears the observed set and returns one result.
// Failure timestamps live in a HISTORY_DEPTH-entry ring; before each new
// failure is logged, entries older than ten seconds per unit of the alert
// threshold are dropped one at a time. After a fatal failure, check cycles
// are accepted and dropped without a result; ok reports are always accepted.
// Timing: an ok report leaves the controller idle and a new request can follow
// in the next cycle. A check cycle holds the request port through DECIDE, then
// for each failure logged (at most two) AGE_READ and AGE_CHECK, repeated per
// aged-out entry, and EMIT; the aging walk is bounded by the single ring read port.
// A result waiting in the output register does not block the request port; a
// check only waits at its last step if the previous result is still unread.
// CSR map: the alert threshold at byte 0x0 (8 bits, reset 3), monitored_groups
// at byte 0x8 (64 bits, reset 0). The ring needs no clearing after reset.
module queue_health_watchdog_top #(
   parameter int GROUPS           = qhw_pkg::GROUPS_DEFAULT,
   parameter int HISTORY_DEPTH    = qhw_pkg::HISTORY_DEPTH_DEFAULT,
   parameter int TICKS_PER_SECOND = qhw_pkg::TICKS_PER_SECOND_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire qhw_pkg::req_type                     req_data,
   // result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output qhw_pkg::rsp_type                          rsp_data,
   // configuration port
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [qhw_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  wire logic [qhw_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [qhw_pkg::CSR_DATA_WIDTH-1:0]        csr_prdata,
   output logic                                      csr_pready
);

   logic [7:0]  threshold_ff;
   logic [63:0] groups_ff;
   logic        csr_write;
   logic        csr_index;

   qhw_pkg::cmd_type  cmd;
   qhw_pkg::stat_type stat;

   // Registers sit 8 bytes apart; decode on the register-select bit.
   assign csr_index  = csr_paddr[3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= qhw_pkg::THRESHOLD_RESET;
         groups_ff    <= '0;
      end else if (csr_write) begin
         if (csr_index == qhw_pkg::CSR_IDX_THRESHOLD) begin
            threshold_ff <= csr_pwdata[7:0];
         end else begin
            groups_ff <= csr_pwdata;
         end
      end
   end

   // Read back the selected register, zero-extended to the bus width.
   always_comb begin
      if (csr_index == qhw_pkg::CSR_IDX_GROUPS) begin
         csr_prdata = groups_ff;
      end else begin
         csr_prdata = {56'd0, threshold_ff};
      end
   end

   // Sequencer: accepts requests, walks the aging loop, releases results.
   qhw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Group sets, failure ring and the result register.
   qhw_dp #(
      .GROUPS           (GROUPS),
      .HISTORY_DEPTH    (HISTORY_DEPTH),
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .threshold (threshold_ff),
      .monitored (groups_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### design/qhw_ctrl.sv
// Controller state machine of the queue health watchdog.
`timescale 1ns / 1ps
`default_nettype none

module qhw_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_kind,
   output logic                   req_ready,
   input  wire qhw_pkg::stat_type stat,
   output qhw_pkg::cmd_type       cmd
);

   qhw_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qhw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         qhw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == qhw_pkg::KIND_REPORT) begin
                  cmd.record = 1'b1;
               end else if (!stat.fatal) begin
                  cmd.start = 1'b1;
                  state_in  = qhw_pkg::ST_DECIDE;
               end
            end
         end
         qhw_pkg::ST_DECIDE: begin
            if (stat.cat_pend || stat.grp_pend) begin
               state_in = qhw_pkg::ST_AGE_READ;
            end else begin
               state_in = qhw_pkg::ST_EMIT;
            end
         end
         qhw_pkg::ST_AGE_READ: begin
            state_in = qhw_pkg::ST_AGE_CHECK;
         end
         qhw_pkg::ST_AGE_CHECK: begin
            if (stat.expired) begin
               cmd.drop = 1'b1;
               state_in = qhw_pkg::ST_AGE_READ;
            end else begin
               cmd.commit = 1'b1;
               state_in   = qhw_pkg::ST_DECIDE;
            end
         end
         qhw_pkg::ST_EMIT: begin
            if (!stat.out_busy) begin
               cmd.emit = 1'b1;
               state_in = qhw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = qhw_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### design/qhw_dp.sv
// Datapath of the queue health watchdog: group sets, failure ring, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "queue_health_watchdog_top_assert.svh"

module qhw_dp #(
   parameter int GROUPS           = qhw_pkg::GROUPS_DEFAULT,
   parameter int HISTORY_DEPTH    = qhw_pkg::HISTORY_DEPTH_DEFAULT,
   parameter int TICKS_PER_SECOND = qhw_pkg::TICKS_PER_SECOND_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire qhw_pkg::cmd_type cmd,
   output qhw_pkg::stat_type     stat,
   input  wire qhw_pkg::req_type req_data,
   input  wire logic [7:0]       threshold,
   input  wire logic [63:0]      monitored,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output qhw_pkg::rsp_type      rsp_data
);

   localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam int SW = CW + 1;
   localparam logic [63:0] GMASK     = qhw_pkg::group_mask(GROUPS);
   localparam logic [31:0] AGE_SCALE = 32'(qhw_pkg::AGE_TENS * TICKS_PER_SECOND);
   localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
   localparam logic [IW-1:0] LAST_C  = IW'(HISTORY_DEPTH - 1);

   logic [31:0] ring_mem [HISTORY_DEPTH];
   logic [31:0] ring_rd_ff;
   logic        ring_we;
   logic [IW-1:0] ring_slot;

   logic [63:0]   observed_ff, observed_in;
   logic [63:0]   expected_ff, expected_in;
   logic          first_ff, first_in;
   logic          fatal_ff, fatal_in;
   logic [IW-1:0] oldest_ff, oldest_in;
   logic [CW-1:0] held_ff, held_in;
   logic          cat_pend_ff, cat_pend_in;
   logic          grp_pend_ff, grp_pend_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [31:0]   window_ff;
   logic [31:0]   now_ff, now_in;
   logic [31:0]   cval_ff, cval_in;
   logic          cfail_ff, cfail_in;
   logic          gfail_ff, gfail_in;
   logic [63:0]   diff_ff, diff_in;
   qhw_pkg::rsp_type rsp_ff, rsp_in;

   logic [IW-1:0] oldest_next;
   logic [SW-1:0] slot_sum;
   logic [31:0]   age_diff;
   logic [63:0]   cur_diff;

   always_comb begin
      oldest_next = (oldest_ff == LAST_C) ? '0 : oldest_ff + 1'b1;
      slot_sum    = SW'(oldest_ff) + SW'(held_ff);
      if (slot_sum >= SW'(HISTORY_DEPTH)) begin
         slot_sum = slot_sum - SW'(HISTORY_DEPTH);
      end
      age_diff = now_ff - (ring_rd_ff + window_ff);
      cur_diff = (observed_ff ^ expected_ff) & GMASK;
   end

   always_comb begin
      observed_in  = observed_ff;
      expected_in  = expected_ff;
      first_in     = first_ff;
      fatal_in     = fatal_ff;
      oldest_in    = oldest_ff;
      held_in      = held_ff;
      cat_pend_in  = cat_pend_ff;
      grp_pend_in  = grp_pend_ff;
      rsp_valid_in = rsp_valid_ff;
      now_in       = now_ff;
      cval_in      = cval_ff;
      cfail_in     = cfail_ff;
      gfail_in     = gfail_ff;
      diff_in      = diff_ff;
      rsp_in       = rsp_ff;
      ring_we      = 1'b0;
      ring_slot    = IW'(slot_sum);

      if (cmd.record && ({1'b0, req_data.group_index} < 7'(GROUPS))) begin
         observed_in[req_data.group_index] = 1'b1;
      end

      if (cmd.start) begin
         now_in      = req_data.now_time;
         cval_in     = qhw_pkg::swap_bytes(req_data.catas_word);
         cfail_in    = (req_data.catas_word != 32'd0);
         cat_pend_in = (req_data.catas_word != 32'd0);
         diff_in     = cur_diff;
         gfail_in    = !first_ff && (cur_diff != 64'd0);
         grp_pend_in = !first_ff && (cur_diff != 64'd0);
         first_in    = 1'b0;
      end

      if (cmd.drop) begin
         oldest_in = oldest_next;
         held_in   = held_ff - 1'b1;
      end

      if (cmd.commit) begin
         ring_we = 1'b1;
         if (held_ff == DEPTH_C) begin
            ring_slot = oldest_ff;
            oldest_in = oldest_next;
         end else begin
            held_in = held_ff + 1'b1;
         end
         if (cat_pend_ff) begin
            cat_pend_in = 1'b0;
            fatal_in    = 1'b1;
         end else begin
            grp_pend_in = 1'b0;
         end
      end

      if (cmd.emit) begin
         observed_in          = '0;
         expected_in          = monitored & GMASK;
         rsp_valid_in         = 1'b1;
         rsp_in.alert         = fatal_ff || (32'(held_ff) >= 32'(threshold));
         rsp_in.fatal         = fatal_ff;
         rsp_in.failure_count = 5'(held_ff);
         rsp_in.catas_failed  = cfail_ff;
         rsp_in.catas_value   = cval_ff;
         rsp_in.group_failed  = gfail_ff;
         rsp_in.failed_group  = gfail_ff ? qhw_pkg::lowest_set(diff_ff) : 6'd0;
         rsp_in.session_mask  = monitored & GMASK;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         observed_ff  <= '0;
         expected_ff  <= '0;
         first_ff     <= 1'b1;
         fatal_ff     <= 1'b0;
         oldest_ff    <= '0;
         held_ff      <= '0;
         cat_pend_ff  <= 1'b0;
         grp_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         observed_ff  <= observed_in;
         expected_ff  <= expected_in;
         first_ff     <= first_in;
         fatal_ff     <= fatal_in;
         oldest_ff    <= oldest_in;
         held_ff      <= held_in;
         cat_pend_ff  <= cat_pend_in;
         grp_pend_ff  <= grp_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= 32'(32'(threshold) * AGE_SCALE);
      now_ff    <= now_in;
      cval_ff   <= cval_in;
      cfail_ff  <= cfail_in;
      gfail_ff  <= gfail_in;
      diff_ff   <= diff_in;
      rsp_ff    <= rsp_in;
   end

   // Failure timestamp ring; read port always follows the oldest slot.
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_slot] <= now_ff;
      end
      ring_rd_ff <= ring_mem[oldest_ff];
   end

   assign stat.fatal    = fatal_ff;
   assign stat.cat_pend = cat_pend_ff;
   assign stat.grp_pend = grp_pend_ff;
   assign stat.expired  = (held_ff != '0) && (age_diff != 32'd0) && !age_diff[31];
   assign stat.out_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `QHW_ASSERT_NOW(a_drop_nonempty, clock, reset, cmd.drop, held_ff != '0,
      "drop issued on an empty failure ring")
   `QHW_ASSERT_NEXT(a_commit_grows, clock, reset, cmd.commit && (held_ff < DEPTH_C),
      held_ff == CW'($past(held_ff) + 1'b1), "failure count did not grow on log")
   `QHW_ASSERT_NEXT(a_fatal_sticky, clock, reset, fatal_ff, fatal_ff,
      "fatal flag cleared outside reset")
   `QHW_ASSERT_NEXT(a_emit_shows, clock, reset, cmd.emit, rsp_valid_ff,
      "emitted result not presented")

endmodule

`default_nettype wire
